FILE: hdl/kmpd_pkg.sv
// ----------------------------------------------------------------------------
// kmpd_pkg
// Types, constants and the key code ROM shared by the packet decoder.
// ----------------------------------------------------------------------------
package kmpd_pkg;

  localparam int unsigned AsciiTableSize = 115;

  localparam logic [7:0] ThreshReset = 8'd248;
  localparam logic [9:0] XLimitReset = 10'd640;
  localparam logic [9:0] YLimitReset = 10'd400;
  localparam logic [9:0] PosXReset   = 10'd320;
  localparam logic [9:0] PosYReset   = 10'd200;

  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_XLIMIT = 2'd1,
    REG_YLIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_WAIT_X = 3'b010,
    PH_WAIT_Y = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic       fault;
  } state_t;

  typedef struct packed {
    logic [7:0] thresh;
    logic [9:0] x_limit;
    logic [9:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic       entry_valid;
    logic [7:0] scan_code;
    logic [6:0] ascii_char;
    logic [9:0] pointer_x;
    logic [9:0] pointer_y;
    logic       fault;
  } result_t;

  function automatic logic [6:0] key_ascii(input logic [7:0] code);
    logic [6:0] a;
    case (code)
      8'd1:    a = 7'h1B;
      8'd2:    a = 7'h31;
      8'd3:    a = 7'h32;
      8'd4:    a = 7'h33;
      8'd5:    a = 7'h34;
      8'd6:    a = 7'h35;
      8'd7:    a = 7'h36;
      8'd8:    a = 7'h37;
      8'd9:    a = 7'h38;
      8'd10:   a = 7'h39;
      8'd11:   a = 7'h30;
      8'd12:   a = 7'h2D;
      8'd13:   a = 7'h3D;
      8'd14:   a = 7'h08;
      8'd15:   a = 7'h09;
      8'd16:   a = 7'h71;
      8'd17:   a = 7'h77;
      8'd18:   a = 7'h65;
      8'd19:   a = 7'h72;
      8'd20:   a = 7'h74;
      8'd21:   a = 7'h79;
      8'd22:   a = 7'h75;
      8'd23:   a = 7'h69;
      8'd24:   a = 7'h6F;
      8'd25:   a = 7'h70;
      8'd26:   a = 7'h5B;
      8'd27:   a = 7'h5D;
      8'd28:   a = 7'h0D;
      8'd30:   a = 7'h61;
      8'd31:   a = 7'h73;
      8'd32:   a = 7'h64;
      8'd33:   a = 7'h66;
      8'd34:   a = 7'h67;
      8'd35:   a = 7'h68;
      8'd36:   a = 7'h6A;
      8'd37:   a = 7'h6B;
      8'd38:   a = 7'h6C;
      8'd39:   a = 7'h3B;
      8'd40:   a = 7'h27;
      8'd41:   a = 7'h60;
      8'd43:   a = 7'h5C;
      8'd44:   a = 7'h7A;
      8'd45:   a = 7'h78;
      8'd46:   a = 7'h63;
      8'd47:   a = 7'h76;
      8'd48:   a = 7'h62;
      8'd49:   a = 7'h6E;
      8'd50:   a = 7'h6D;
      8'd51:   a = 7'h2C;
      8'd52:   a = 7'h2E;
      8'd53:   a = 7'h2F;
      8'd57:   a = 7'h20;
      8'd74:   a = 7'h2D;
      8'd78:   a = 7'h2B;
      8'd83:   a = 7'h7F;
      8'd99:   a = 7'h28;
      8'd100:  a = 7'h29;
      8'd101:  a = 7'h2F;
      8'd102:  a = 7'h2A;
      8'd103:  a = 7'h37;
      8'd104:  a = 7'h38;
      8'd105:  a = 7'h39;
      8'd106:  a = 7'h34;
      8'd107:  a = 7'h35;
      8'd108:  a = 7'h36;
      8'd109:  a = 7'h31;
      8'd110:  a = 7'h32;
      8'd111:  a = 7'h33;
      8'd112:  a = 7'h30;
      8'd113:  a = 7'h2E;
      8'd114:  a = 7'h0D;
      default: a = 7'h00;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/kmpd_core.sv
// ----------------------------------------------------------------------------
// kmpd_core
// Decodes one received byte against the current state: key entries, mouse
// header detection, clamped pointer updates and the sticky fault.
// ----------------------------------------------------------------------------
module kmpd_core (
  input  logic [7:0]       rx_byte_i,
  input  logic             irq_flag_i,
  input  kmpd_pkg::state_t state_i,
  input  kmpd_pkg::cfg_t   cfg_i,
  output kmpd_pkg::state_t state_o,
  output kmpd_pkg::result_t result_o
);
  import kmpd_pkg::*;

  logic              valid;
  logic [7:0]        code;
  logic [6:0]        ascii;
  logic signed [11:0] delta;
  logic signed [11:0] sum_x;
  logic signed [11:0] sum_y;
  logic [9:0]        clamp_x;
  logic [9:0]        clamp_y;

  assign delta = 12'(signed'(rx_byte_i));
  assign sum_x = signed'({2'b00, state_i.pos_x}) + delta;
  assign sum_y = signed'({2'b00, state_i.pos_y}) + delta;

  always_comb begin
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > signed'({2'b00, cfg_i.x_limit})) begin
      clamp_x = cfg_i.x_limit;
    end else begin
      clamp_x = sum_x[9:0];
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > signed'({2'b00, cfg_i.y_limit})) begin
      clamp_y = cfg_i.y_limit;
    end else begin
      clamp_y = sum_y[9:0];
    end
  end

  always_comb begin
    state_o = state_i;
    valid   = 1'b0;
    code    = '0;
    ascii   = '0;
    if (!state_i.fault) begin
      if (!irq_flag_i) begin
        state_o.fault = 1'b1;
      end else begin
        case (state_i.phase)
          PH_IDLE: begin
            if (rx_byte_i < cfg_i.thresh) begin
              if (!rx_byte_i[7]) begin
                valid = 1'b1;
                code  = rx_byte_i;
                ascii = (32'(rx_byte_i) < AsciiTableSize) ? key_ascii(rx_byte_i) : 7'h00;
              end
            end else begin
              valid         = 1'b1;
              code          = rx_byte_i;
              state_o.phase = PH_WAIT_X;
            end
          end
          PH_WAIT_X: begin
            state_o.pos_x = clamp_x;
            state_o.phase = PH_WAIT_Y;
          end
          default: begin
            state_o.pos_y = clamp_y;
            state_o.phase = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign result_o.entry_valid = valid;
  assign result_o.scan_code   = code;
  assign result_o.ascii_char  = ascii;
  assign result_o.pointer_x   = state_o.pos_x;
  assign result_o.pointer_y   = state_o.pos_y;
  assign result_o.fault       = state_o.fault;

endmodule

FILE: hdl/keyboard_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// keyboard_mouse_packet_decoder
// Keyboard scan code and relative mouse packet decoder with stream ports.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; one result per input byte.
// Throughput: one byte per cycle while m_axis_tready does not stall the
//   result register; the phase and pointer update is combinational between
//   the input and result registers.
// Reset: phase idle, pointer at 320/200, fault clear, registers at defaults;
//   no clearing pass, usable from the first cycle after reset.
module keyboard_mouse_packet_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] irq_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] scan_code, [14:8] ascii_char, [24:15] pointer_x, [34:25] pointer_y,
  // [39:35] zero
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [0] entry_valid, [1] fault
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  import kmpd_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_irq_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_q;
  state_t     state_q, state_d;
  cfg_t       cfg_q;
  result_t    result;
  logic       out_adv;

  kmpd_core u_core (
    .rx_byte_i  (in_byte_q),
    .irq_flag_i (in_irq_q),
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .state_o    (state_d),
    .result_o   (result)
  );

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_vld_d  = s_axis_tready ? s_axis_tvalid : in_vld_q;
    out_vld_d = out_adv ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      state_q.phase <= PH_IDLE;
      state_q.pos_x <= PosXReset;
      state_q.pos_y <= PosYReset;
      state_q.fault <= 1'b0;
      cfg_q.thresh  <= ThreshReset;
      cfg_q.x_limit <= XLimitReset;
      cfg_q.y_limit <= YLimitReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (out_adv && in_vld_q) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_THRESH: cfg_q.thresh  <= cfg_data_i[7:0];
          REG_XLIMIT: cfg_q.x_limit <= cfg_data_i;
          REG_YLIMIT: cfg_q.y_limit <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_irq_q  <= s_axis_tuser;
    end
    if (out_adv && in_vld_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, out_q.pointer_y, out_q.pointer_x,
                          out_q.ascii_char, out_q.scan_code};
  assign m_axis_tuser  = {out_q.fault, out_q.entry_valid};

  a_fault_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fault |=> state_q.fault)
    else $error("fault flag cleared");

  a_frozen_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fault |=> $stable(state_q.pos_x) && $stable(state_q.pos_y))
    else $error("pointer moved after fault");

  a_entry_no_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.entry_valid |-> !out_q.fault)
    else $error("entry emitted with fault set");

  a_phase_no_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv && in_vld_q && state_q.phase != PH_IDLE |=> !out_q.entry_valid)
    else $error("entry emitted during mouse delta byte");

endmodule

FILE: bench/kmpd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmpd_checker
// Watches the byte, entry and register channels of the packet decoder. It
// keeps its own copy of the decoder state and registers, predicts the entry
// for every accepted byte and compares each accepted entry field by field.
// ----------------------------------------------------------------------------
module kmpd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  import kmpd_pkg::*;

  logic [6:0] key_map [AsciiTableSize];
  cfg_t       regs_q;
  state_t     decoder_q;
  result_t    entry_q [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    key_map = '{
      'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
      'h37, 'h38, 'h39, 'h30, 'h2D, 'h3D, 'h08, 'h09,
      'h71, 'h77, 'h65, 'h72, 'h74, 'h79, 'h75, 'h69,
      'h6F, 'h70, 'h5B, 'h5D, 'h0D, 'h00, 'h61, 'h73,
      'h64, 'h66, 'h67, 'h68, 'h6A, 'h6B, 'h6C, 'h3B,
      'h27, 'h60, 'h00, 'h5C, 'h7A, 'h78, 'h63, 'h76,
      'h62, 'h6E, 'h6D, 'h2C, 'h2E, 'h2F, 'h00, 'h00,
      'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h2D, 'h00, 'h00, 'h00, 'h2B, 'h00,
      'h00, 'h00, 'h00, 'h7F, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
      'h00, 'h00, 'h00, 'h28, 'h29, 'h2F, 'h2A, 'h37,
      'h38, 'h39, 'h34, 'h35, 'h36, 'h31, 'h32, 'h33,
      'h30, 'h2E, 'h0D
    };
  end

  function automatic logic [9:0] clamp_move(input logic [9:0] pos, input logic [7:0] delta,
                                            input logic [9:0] ceiling);
    int v;
    v = int'(pos) + int'($signed(delta));
    if (v > int'(ceiling)) v = int'(ceiling);
    else if (v < 0) v = 0;
    return v[9:0];
  endfunction

  function automatic result_t decode_byte(input logic [7:0] rx, input logic irq);
    result_t r;
    r = '0;
    if (!decoder_q.fault) begin
      if (!irq) begin
        decoder_q.fault = 1'b1;
      end else begin
        case (decoder_q.phase)
          PH_IDLE: begin
            if (rx >= regs_q.thresh) begin
              r.entry_valid   = 1'b1;
              r.scan_code     = rx;
              decoder_q.phase = PH_WAIT_X;
            end else if (!rx[7]) begin
              r.entry_valid = 1'b1;
              r.scan_code   = rx;
              if (rx < AsciiTableSize) r.ascii_char = key_map[rx];
            end
          end
          PH_WAIT_X: begin
            decoder_q.pos_x = clamp_move(decoder_q.pos_x, rx, regs_q.x_limit);
            decoder_q.phase = PH_WAIT_Y;
          end
          default: begin
            decoder_q.pos_y = clamp_move(decoder_q.pos_y, rx, regs_q.y_limit);
            decoder_q.phase = PH_IDLE;
          end
        endcase
      end
    end
    r.pointer_x = decoder_q.pos_x;
    r.pointer_y = decoder_q.pos_y;
    r.fault     = decoder_q.fault;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      regs_q    = '{thresh: ThreshReset, x_limit: XLimitReset, y_limit: YLimitReset};
      decoder_q = '{phase: PH_IDLE, pos_x: PosXReset, pos_y: PosYReset, fault: 1'b0};
      entry_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_THRESH: regs_q.thresh  = cfg_data_i[7:0];
          REG_XLIMIT: regs_q.x_limit = cfg_data_i;
          REG_YLIMIT: regs_q.y_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) entry_q.push_back(decode_byte(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (entry_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: entry expected none, got tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = entry_q.pop_front();
          check_field("entry_valid", want.entry_valid, m_axis_tuser[0]);
          check_field("scan_code", want.scan_code, m_axis_tdata[7:0]);
          check_field("ascii_char", want.ascii_char, m_axis_tdata[14:8]);
          check_field("pointer_x", want.pointer_x, m_axis_tdata[24:15]);
          check_field("pointer_y", want.pointer_y, m_axis_tdata[34:25]);
          check_field("fault", want.fault, m_axis_tuser[1]);
        end
      end
    end
    pending_o = entry_q.size();
  end

endmodule

FILE: bench/tb_keyboard_mouse_packet_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_mouse_packet_decoder
// Feeds key codes, mouse packets and register settings to the decoder with
// random gaps on both streams; the checker predicts and compares each entry.
// A missing interrupt bit is sent only at the very end, as it freezes the
// decoder until reset.
// ----------------------------------------------------------------------------
module tb_keyboard_mouse_packet_decoder;
  import kmpd_pkg::*;

  localparam int unsigned GapMax        = 17;
  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned Phases        = 8;
  localparam int unsigned BytesPerPhase = 250;
  localparam logic [1:0]  RegSpare      = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b1;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [9:0]  cfg_data_i    = '0;
  int unsigned mismatches;
  int unsigned pending;

  logic [7:0]  cur_thresh   = ThreshReset;
  int unsigned triplet_left = 0;
  int unsigned send_calm    = 0;
  int unsigned recv_calm    = 0;

  keyboard_mouse_packet_decoder dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  kmpd_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // runs of back-to-back transactions now and then
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(16, 64);
    return $urandom_range(0, GapMax);
  endfunction

  // mostly whole mouse packets and make codes, some noise
  function automatic logic [7:0] pick_byte();
    logic [7:0]  b;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (triplet_left != 0) begin
      triplet_left--;
      if (roll < 15) return 8'h7F;
      if (roll < 30) return 8'h80;
      return 8'($urandom);
    end
    if (roll < 40) b = 8'($urandom_range(cur_thresh, 255));
    else if (roll < 80 && cur_thresh != 0)
      b = 8'($urandom_range(0, (cur_thresh > 128) ? 127 : cur_thresh - 1));
    else b = 8'($urandom);
    if (b >= cur_thresh) triplet_left = 2;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] rx, input logic irq);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= irq;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] thr, input logic [9:0] xl, input logic [9:0] yl,
                            input bit spare);
    logic [1:0] idx [4];
    logic [9:0] val [4];
    idx = '{REG_THRESH, REG_XLIMIT, REG_YLIMIT, RegSpare};
    val = '{{2'($urandom), thr}, xl, yl, 10'($urandom)};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < (spare ? 4 : 3); i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_thresh = thr;
  endtask

  function automatic logic [9:0] draw_limit();
    if ($urandom_range(0, 3) == 0) return 10'($urandom_range(0, 15));
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] opening [18];
    opening = '{8'h00, 8'h01, 8'h1C, 8'h53, 8'h72, 8'h73, 8'h7F, 8'h80, 8'hF7,
                8'hF8, 8'h7F, 8'h80, 8'hFF, 8'h80, 8'h7F, 8'hFA, 8'h00, 8'hFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i], 1'b1);

    for (int p = 0; p < Phases; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1:       write_regs(8'h80, 10'd1023, 10'd1023, 1'b1);
          2:       write_regs(8'h00, 10'd0, 10'd0, 1'b0);
          3:       write_regs(8'hFF, 10'd100, 10'd50, 1'b0);
          default: write_regs(8'($urandom), draw_limit(), draw_limit(), $urandom_range(0, 1));
        endcase
      end
      for (int n = 0; n < BytesPerPhase; n++) begin
        if ((p == 0 && n == BytesPerPhase / 2) || $urandom_range(0, 299) == 0) drain();
        send_byte(pick_byte(), 1'b1);
      end
    end

    // missing interrupt bit: decoder must stay frozen afterwards
    send_byte(8'($urandom), 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h10, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h01, 1'b1);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/kmpd_pkg.sv
hdl/kmpd_core.sv
hdl/keyboard_mouse_packet_decoder.sv
bench/kmpd_checker.sv
bench/tb_keyboard_mouse_packet_decoder.sv
